@@ rtl/bezier_curve_point_evaluator_core_defines.svh @@
// Assertion macros for the Bezier curve point evaluator core.
`ifndef BEZIER_CURVE_POINT_EVALUATOR_CORE_DEFINES_SVH
`define BEZIER_CURVE_POINT_EVALUATOR_CORE_DEFINES_SVH

// Property checked on clk_i, off while rst_ni is low.
`define BCPE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Expression that must never be true.
`define BCPE_ASSERT_NEVER(lbl, expr, msg) \
  `BCPE_ASSERT(lbl, !(expr), msg)

`endif

@@ rtl/bcpe_pkg.sv @@
// Shared types and constants of the Bezier curve point evaluator.
package bcpe_pkg;

  localparam int IDX_W     = 4;
  localparam int IN_W      = 16;
  localparam int FRAC_BITS = 8;
  localparam int COORD_W   = IN_W + FRAC_BITS;
  localparam int CNT_W     = 5;

  localparam int QUEUE_DEPTH = 2;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  localparam logic REG_POINT_COUNT = 1'b0;
  localparam logic [CNT_W-1:0] POINT_COUNT_RESET = 5'd2;

  typedef struct packed {
    logic             is_eval;
    logic [IDX_W-1:0] idx;
    logic [IN_W-1:0]  x;
    logic [IN_W-1:0]  y;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

@@ rtl/bcpe_ram.sv @@
// Generic single write port, single read port RAM with registered read.
module bcpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bcpe_queue.sv @@
// Short command queue between the front and back parts.
module bcpe_queue #(
  parameter int WIDTH = 54
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [WIDTH-1:0]   wdata_i,
  input  logic               pop_i,
  output logic [WIDTH-1:0]   rdata_o,
  output bcpe_pkg::q_stat_t  stat_o
);

  localparam int DEPTH = bcpe_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ rtl/bcpe_front.sv @@
// Front part: accepts items, drops out-of-range loads, saturates t.
module bcpe_front #(
  parameter int MAX_POINTS = 16,
  parameter int PARAM_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic                          func_i,
  input  logic [bcpe_pkg::IDX_W-1:0]    point_index_i,
  input  logic signed [bcpe_pkg::IN_W-1:0] point_x_i,
  input  logic signed [bcpe_pkg::IN_W-1:0] point_y_i,
  input  logic [PARAM_BITS:0]           curve_param_i,
  input  bcpe_pkg::q_stat_t             q_stat_i,
  output logic                          q_push_o,
  output bcpe_pkg::cmd_t                q_cmd_o,
  output logic [PARAM_BITS:0]           q_t_o
);

  localparam int TW = PARAM_BITS + 1;

  logic              vld_q, vld_d;
  bcpe_pkg::cmd_t    cmd_q, cmd_d;
  logic [TW-1:0]     t_q, t_d;
  logic              accept, keep, is_eval;
  logic [TW-1:0]     t_sat;

  assign full_o   = vld_q && q_stat_i.full;
  assign accept   = push_i && !full_o;
  assign is_eval  = (func_i == bcpe_pkg::FUNC_EVAL);
  assign keep     = is_eval || (32'(point_index_i) < MAX_POINTS);
  assign t_sat    = curve_param_i[PARAM_BITS] ? {1'b1, {PARAM_BITS{1'b0}}} : curve_param_i;
  assign q_push_o = vld_q;
  assign q_cmd_o  = cmd_q;
  assign q_t_o    = t_q;

  always_comb begin
    vld_d = vld_q;
    cmd_d = cmd_q;
    t_d   = t_q;
    if (vld_q && !q_stat_i.full) begin
      vld_d = 1'b0;
    end
    if (accept) begin
      vld_d         = keep;
      cmd_d.is_eval = is_eval;
      cmd_d.idx     = point_index_i;
      cmd_d.x       = point_x_i;
      cmd_d.y       = point_y_i;
      t_d           = t_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    t_q   <= t_d;
  end

endmodule

@@ rtl/bcpe_back.sv @@
// Back part: control point store, de Casteljau sequencer, lerp datapath, result register.
module bcpe_back #(
  parameter int MAX_POINTS = 16,
  parameter int PARAM_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bcpe_pkg::q_stat_t                q_stat_i,
  input  bcpe_pkg::cmd_t                   q_cmd_i,
  input  logic [PARAM_BITS:0]              q_t_i,
  output logic                             q_pop_o,
  input  logic [bcpe_pkg::CNT_W-1:0]       point_count_i,
  input  logic                             pop_i,
  output logic                             empty_o,
  output logic signed [bcpe_pkg::COORD_W-1:0] curve_x_o,
  output logic signed [bcpe_pkg::COORD_W-1:0] curve_y_o,
  output logic                             hold_o
);

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int TW  = PARAM_BITS + 1;
  localparam int XW  = bcpe_pkg::COORD_W;
  localparam int IW  = bcpe_pkg::IN_W;
  localparam int DW  = XW + 1;
  localparam int PW  = DW + TW + 1;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_HOLD} state_e;

  state_e              state_q, state_d;
  logic [TW-1:0]       t_q, t_d;
  logic [CW-1:0]       npts_q, npts_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic                src_work_q, src_work_d;
  logic                rd_vld_q, rd_vld_d;
  logic [AW-1:0]       rd_idx_q, rd_idx_d;
  logic [XW-1:0]       prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic                d_vld_q, d_vld_d;
  logic [AW-1:0]       d_idx_q, d_idx_d;
  logic [XW-1:0]       a_x_q, a_x_d, a_y_q, a_y_d;
  logic signed [DW-1:0] dx_x_q, dx_x_d, dx_y_q, dx_y_d;
  logic                mul_vld_q, mul_vld_d;
  logic [AW-1:0]       mul_idx_q, mul_idx_d;
  logic [XW-1:0]       a2_x_q, a2_x_d, a2_y_q, a2_y_d;
  logic signed [PW-1:0] px_x_q, px_x_d, px_y_q, px_y_d;
  logic [XW-1:0]       res_x_q, res_x_d, res_y_q, res_y_d;
  logic                out_vld_q, out_vld_d;
  logic [XW-1:0]       out_x_q, out_x_d, out_y_q, out_y_d;

  logic [CW-1:0]       n_in;
  logic                rd_en, ctrl_we;
  logic [2*IW-1:0]     ctrl_rdata;
  logic [2*XW-1:0]     work_rdata, work_wdata;
  logic [XW-1:0]       rv_x, rv_y;
  logic signed [TW:0]  t_sig;
  logic signed [PW-1:0] sh_x, sh_y;
  logic [DW-1:0]       sum_x, sum_y;

  bcpe_ram #(.WIDTH(2 * IW), .DEPTH(MAX_POINTS)) u_ctrl_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_we),
    .waddr_i (AW'(q_cmd_i.idx)),
    .wdata_i ({q_cmd_i.x, q_cmd_i.y}),
    .re_i    (rd_en),
    .raddr_i (idx_q),
    .rdata_o (ctrl_rdata)
  );

  bcpe_ram #(.WIDTH(2 * XW), .DEPTH(MAX_POINTS)) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (mul_vld_q),
    .waddr_i (mul_idx_q),
    .wdata_i (work_wdata),
    .re_i    (rd_en),
    .raddr_i (idx_q),
    .rdata_o (work_rdata)
  );

  assign rd_en = (state_q == ST_RUN);
  assign rv_x  = src_work_q ? work_rdata[2*XW-1:XW]
                            : {ctrl_rdata[2*IW-1:IW], {bcpe_pkg::FRAC_BITS{1'b0}}};
  assign rv_y  = src_work_q ? work_rdata[XW-1:0]
                            : {ctrl_rdata[IW-1:0], {bcpe_pkg::FRAC_BITS{1'b0}}};
  assign t_sig = {1'b0, t_q};

  // floor((b - a) * t / 2^PARAM_BITS) is an arithmetic shift
  assign sh_x  = px_x_q >>> PARAM_BITS;
  assign sh_y  = px_y_q >>> PARAM_BITS;
  assign sum_x = DW'(sh_x) + {a2_x_q[XW-1], a2_x_q};
  assign sum_y = DW'(sh_y) + {a2_y_q[XW-1], a2_y_q};
  assign work_wdata = {sum_x[XW-1:0], sum_y[XW-1:0]};

  assign empty_o   = !out_vld_q;
  assign curve_x_o = out_x_q;
  assign curve_y_o = out_y_q;
  assign hold_o    = (state_q == ST_HOLD);

  always_comb begin
    if (32'(point_count_i) < 2) begin
      n_in = CW'(1);
    end else if (32'(point_count_i) > MAX_POINTS) begin
      n_in = CW'(MAX_POINTS);
    end else begin
      n_in = CW'(point_count_i);
    end
  end

  always_comb begin
    state_d    = state_q;
    t_d        = t_q;
    npts_d     = npts_q;
    idx_d      = idx_q;
    src_work_d = src_work_q;
    out_vld_d  = out_vld_q;
    out_x_d    = out_x_q;
    out_y_d    = out_y_q;
    res_x_d    = res_x_q;
    res_y_d    = res_y_q;
    q_pop_o    = 1'b0;
    ctrl_we    = 1'b0;

    // lerp pipeline: read -> difference -> multiply -> add and write back
    rd_vld_d  = rd_en;
    rd_idx_d  = idx_q;
    prev_x_d  = rd_vld_q ? rv_x : prev_x_q;
    prev_y_d  = rd_vld_q ? rv_y : prev_y_q;
    d_vld_d   = rd_vld_q && (rd_idx_q != '0);
    d_idx_d   = rd_idx_q - AW'(1);
    a_x_d     = prev_x_q;
    a_y_d     = prev_y_q;
    dx_x_d    = {rv_x[XW-1], rv_x} - {prev_x_q[XW-1], prev_x_q};
    dx_y_d    = {rv_y[XW-1], rv_y} - {prev_y_q[XW-1], prev_y_q};
    mul_vld_d = d_vld_q;
    mul_idx_d = d_idx_q;
    a2_x_d    = a_x_q;
    a2_y_d    = a_y_q;
    px_x_d    = dx_x_q * t_sig;
    px_y_d    = dx_y_q * t_sig;

    if (mul_vld_q && (mul_idx_q == '0)) begin
      res_x_d = sum_x[XW-1:0];
      res_y_d = sum_y[XW-1:0];
    end else if (rd_vld_q && (rd_idx_q == '0)) begin
      res_x_d = rv_x;
      res_y_d = rv_y;
    end

    if (pop_i && out_vld_q) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty) begin
          q_pop_o = 1'b1;
          if (q_cmd_i.is_eval) begin
            t_d        = q_t_i;
            npts_d     = n_in;
            idx_d      = '0;
            src_work_d = 1'b0;
            state_d    = ST_RUN;
          end else begin
            ctrl_we = 1'b1;
          end
        end
      end
      ST_RUN: begin
        idx_d = idx_q + AW'(1);
        if ((CW'(idx_q) + CW'(1)) == npts_q) begin
          idx_d   = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !d_vld_q && !mul_vld_q) begin
          if (npts_q <= CW'(2)) begin
            state_d = ST_HOLD;
          end else begin
            npts_d     = npts_q - CW'(1);
            src_work_d = 1'b1;
            idx_d      = '0;
            state_d    = ST_RUN;
          end
        end
      end
      ST_HOLD: begin
        if (!out_vld_q || pop_i) begin
          out_vld_d = 1'b1;
          out_x_d   = res_x_q;
          out_y_d   = res_y_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      t_q        <= '0;
      npts_q     <= '0;
      idx_q      <= '0;
      src_work_q <= 1'b0;
      rd_vld_q   <= 1'b0;
      rd_idx_q   <= '0;
      prev_x_q   <= '0;
      prev_y_q   <= '0;
      d_vld_q    <= 1'b0;
      d_idx_q    <= '0;
      a_x_q      <= '0;
      a_y_q      <= '0;
      dx_x_q     <= '0;
      dx_y_q     <= '0;
      mul_vld_q  <= 1'b0;
      mul_idx_q  <= '0;
      a2_x_q     <= '0;
      a2_y_q     <= '0;
      px_x_q     <= '0;
      px_y_q     <= '0;
      res_x_q    <= '0;
      res_y_q    <= '0;
      out_vld_q  <= 1'b0;
      out_x_q    <= '0;
      out_y_q    <= '0;
    end else begin
      state_q    <= state_d;
      t_q        <= t_d;
      npts_q     <= npts_d;
      idx_q      <= idx_d;
      src_work_q <= src_work_d;
      rd_vld_q   <= rd_vld_d;
      rd_idx_q   <= rd_idx_d;
      prev_x_q   <= prev_x_d;
      prev_y_q   <= prev_y_d;
      d_vld_q    <= d_vld_d;
      d_idx_q    <= d_idx_d;
      a_x_q      <= a_x_d;
      a_y_q      <= a_y_d;
      dx_x_q     <= dx_x_d;
      dx_y_q     <= dx_y_d;
      mul_vld_q  <= mul_vld_d;
      mul_idx_q  <= mul_idx_d;
      a2_x_q     <= a2_x_d;
      a2_y_q     <= a2_y_d;
      px_x_q     <= px_x_d;
      px_y_q     <= px_y_d;
      res_x_q    <= res_x_d;
      res_y_q    <= res_y_d;
      out_vld_q  <= out_vld_d;
      out_x_q    <= out_x_d;
      out_y_q    <= out_y_d;
    end
  end

endmodule

@@ rtl/bezier_curve_point_evaluator_core.sv @@
// Top level of the Bezier curve point evaluator: config register, front, queue, back.
//
// Items enter on push/full. func_i low loads point_x_i/point_y_i into slot
// point_index_i (slots at or above MAX_POINTS are dropped); func_i high
// evaluates the curve at t = curve_param_i / 2^PARAM_BITS (saturated at 1)
// over control points 0 .. point_count-1 (point_count clamped to 1 .. MAX_POINTS),
// giving one item on empty/pop with curve_x_o/curve_y_o in 8 fraction bits.
// Loads give no result. point_count is written through the APB port at address 0.
// An item is registered in the front and passes through a two-entry queue.
// A load is written into the control point store from the idle state. An
// evaluation of n points runs n-1 passes, each reading the working points
// once through one RAM read port and two pipelined multipliers (x and y);
// one evaluation runs at a time.
// The result waits in an output register; while it is not popped the back
// holds its next result and the front and queue keep taking items until full.
// Reset empties the queue and the output, sets point_count to 2, and leaves
// the control point store undefined until written.
`include "bezier_curve_point_evaluator_core_defines.svh"

module bezier_curve_point_evaluator_core #(
  parameter int MAX_POINTS = 16,
  parameter int PARAM_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic                                func_i,
  input  logic [bcpe_pkg::IDX_W-1:0]          point_index_i,
  input  logic signed [bcpe_pkg::IN_W-1:0]    point_x_i,
  input  logic signed [bcpe_pkg::IN_W-1:0]    point_y_i,
  input  logic [PARAM_BITS:0]                 curve_param_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [bcpe_pkg::COORD_W-1:0] curve_x_o,
  output logic signed [bcpe_pkg::COORD_W-1:0] curve_y_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int TW   = PARAM_BITS + 1;
  localparam int CMDW = $bits(bcpe_pkg::cmd_t);

  logic [bcpe_pkg::CNT_W-1:0] count_q, count_d;
  logic                       reg_sel, cfg_we;

  bcpe_pkg::q_stat_t q_stat;
  logic              q_push, q_pop;
  bcpe_pkg::cmd_t    f_cmd, b_cmd;
  logic [TW-1:0]     f_t;
  logic [CMDW+TW-1:0] q_rdata;
  logic              back_hold;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == bcpe_pkg::REG_POINT_COUNT);
  assign cfg_we  = psel && penable && pwrite && reg_sel;
  assign count_d = cfg_we ? pwdata[bcpe_pkg::CNT_W-1:0] : count_q;
  assign prdata  = reg_sel ? 32'(count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= bcpe_pkg::POINT_COUNT_RESET;
    end else begin
      count_q <= count_d;
    end
  end

  bcpe_front #(.MAX_POINTS(MAX_POINTS), .PARAM_BITS(PARAM_BITS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .func_i        (func_i),
    .point_index_i (point_index_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .curve_param_i (curve_param_i),
    .q_stat_i      (q_stat),
    .q_push_o      (q_push),
    .q_cmd_o       (f_cmd),
    .q_t_o         (f_t)
  );

  bcpe_queue #(.WIDTH(CMDW + TW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i ({f_cmd, f_t}),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .stat_o  (q_stat)
  );

  assign b_cmd = q_rdata[TW +: CMDW];

  bcpe_back #(.MAX_POINTS(MAX_POINTS), .PARAM_BITS(PARAM_BITS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_stat_i      (q_stat),
    .q_cmd_i       (b_cmd),
    .q_t_i         (q_rdata[TW-1:0]),
    .q_pop_o       (q_pop),
    .point_count_i (count_q),
    .pop_i         (pop),
    .empty_o       (empty),
    .curve_x_o     (curve_x_o),
    .curve_y_o     (curve_y_o),
    .hold_o        (back_hold)
  );

  `BCPE_ASSERT_NEVER(a_queue_state, q_stat.empty && q_stat.full, "queue empty and full")
  `BCPE_ASSERT(a_full_from_queue, full |-> q_stat.full, "full raised with queue not full")
  `BCPE_ASSERT(a_result_from_hold, $fell(empty) |-> $past(back_hold), "result not from hold")

endmodule

@@ tb/bezier_curve_point_evaluator_core_tb.sv @@
// Testbench for the Bezier curve point evaluator core: directed and random load and evaluate items, point_count writes.
module bezier_curve_point_evaluator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_POINTS = 16;
  localparam int PARAM_BITS = 16;
  localparam int PW = PARAM_BITS + 1;
  localparam int ONE_PARAM = 1 << PARAM_BITS;
  localparam int EVAL_LATENCY = 250;
  localparam int ITEMS_PER_PHASE = 136;
  localparam longint RUN_LIMIT_NS = 30_000_000;

  typedef struct packed {
    logic signed [bcpe_pkg::COORD_W-1:0] x;
    logic signed [bcpe_pkg::COORD_W-1:0] y;
  } curve_point_t;

  class bezier_point_predictor;
    logic signed [bcpe_pkg::IN_W-1:0] ctrl_x [MAX_POINTS];
    logic signed [bcpe_pkg::IN_W-1:0] ctrl_y [MAX_POINTS];
    logic [bcpe_pkg::CNT_W-1:0] point_count;
    curve_point_t expected_points [$];
    int errors;

    function new();
      point_count = bcpe_pkg::POINT_COUNT_RESET;
      errors = 0;
    endfunction

    function void set_point_count(logic [bcpe_pkg::CNT_W-1:0] cnt);
      point_count = cnt;
    endfunction

    function int pending();
      return expected_points.size();
    endfunction

    // a + floor((b - a) * t / 2^PARAM_BITS), repeated over the working points
    function curve_point_t de_casteljau(logic [PARAM_BITS:0] t_raw);
      longint wx [MAX_POINTS];
      longint wy [MAX_POINTS];
      longint t;
      int n;
      curve_point_t pt;
      t = (t_raw > ONE_PARAM) ? longint'(ONE_PARAM) : longint'(t_raw);
      n = point_count;
      if (n < 1) n = 1;
      if (n > MAX_POINTS) n = MAX_POINTS;
      for (int i = 0; i < n; i++) begin
        wx[i] = longint'(ctrl_x[i]) * (1 << bcpe_pkg::FRAC_BITS);
        wy[i] = longint'(ctrl_y[i]) * (1 << bcpe_pkg::FRAC_BITS);
      end
      for (int r = 1; r < n; r++) begin
        for (int j = 0; j + r < n; j++) begin
          wx[j] = wx[j] + (((wx[j+1] - wx[j]) * t) >>> PARAM_BITS);
          wy[j] = wy[j] + (((wy[j+1] - wy[j]) * t) >>> PARAM_BITS);
        end
      end
      pt.x = wx[0][bcpe_pkg::COORD_W-1:0];
      pt.y = wy[0][bcpe_pkg::COORD_W-1:0];
      return pt;
    endfunction

    function void note_item(logic func, logic [bcpe_pkg::IDX_W-1:0] idx,
                            logic signed [bcpe_pkg::IN_W-1:0] px,
                            logic signed [bcpe_pkg::IN_W-1:0] py, logic [PARAM_BITS:0] t);
      if (func == bcpe_pkg::FUNC_LOAD) begin
        if (idx < MAX_POINTS) begin
          ctrl_x[idx] = px;
          ctrl_y[idx] = py;
        end
      end else begin
        expected_points.push_back(de_casteljau(t));
      end
    endfunction

    task report_error(string what);
      if (errors < 100) $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    task check_point(logic signed [bcpe_pkg::COORD_W-1:0] gx,
                     logic signed [bcpe_pkg::COORD_W-1:0] gy);
      curve_point_t want;
      if (expected_points.size() == 0) begin
        report_error($sformatf("unexpected curve point (%0d, %0d)", gx, gy));
        return;
      end
      want = expected_points.pop_front();
      if (gx !== want.x) report_error($sformatf("curve_x got %0d exp %0d", gx, want.x));
      if (gy !== want.y) report_error($sformatf("curve_y got %0d exp %0d", gy, want.y));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic func_i = bcpe_pkg::FUNC_LOAD;
  logic [bcpe_pkg::IDX_W-1:0] point_index_i = '0;
  logic signed [bcpe_pkg::IN_W-1:0] point_x_i = '0;
  logic signed [bcpe_pkg::IN_W-1:0] point_y_i = '0;
  logic [PARAM_BITS:0] curve_param_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [bcpe_pkg::COORD_W-1:0] curve_x_o;
  logic signed [bcpe_pkg::COORD_W-1:0] curve_y_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bit no_stall = 1'b0;
  bezier_point_predictor curve_points = new();

  bezier_curve_point_evaluator_core #(
    .MAX_POINTS(MAX_POINTS),
    .PARAM_BITS(PARAM_BITS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push(push),
    .full(full),
    .func_i(func_i),
    .point_index_i(point_index_i),
    .point_x_i(point_x_i),
    .point_y_i(point_y_i),
    .curve_param_i(curve_param_i),
    .empty(empty),
    .pop(pop),
    .curve_x_o(curve_x_o),
    .curve_y_o(curve_y_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_stall || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [bcpe_pkg::IN_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      3: return '1;
      default: return bcpe_pkg::IN_W'($urandom());
    endcase
  endfunction

  function automatic logic [PARAM_BITS:0] rand_param();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return PW'(ONE_PARAM);
      2: return PW'(ONE_PARAM - 1);
      3: return PW'(1);
      4, 5: return PW'($urandom_range(0, 2 * ONE_PARAM - 1));
      default: return PW'($urandom_range(0, ONE_PARAM));
    endcase
  endfunction

  task automatic send_item(input logic func, input logic [bcpe_pkg::IDX_W-1:0] idx,
                           input logic signed [bcpe_pkg::IN_W-1:0] px,
                           input logic signed [bcpe_pkg::IN_W-1:0] py,
                           input logic [PARAM_BITS:0] t);
    push <= 1'b1;
    func_i <= func;
    point_index_i <= idx;
    point_x_i <= px;
    point_y_i <= py;
    curve_param_i <= t;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    curve_points.note_item(func, idx, px, py, t);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      push <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic send_random_item();
    logic func;
    func = ($urandom_range(0, 99) < 40) ? bcpe_pkg::FUNC_LOAD : bcpe_pkg::FUNC_EVAL;
    send_item(func, bcpe_pkg::IDX_W'($urandom_range(0, MAX_POINTS - 1)), rand_coord(),
              rand_coord(), rand_param());
    idle_sender(pick_gap());
  endtask

  task automatic wait_results_done();
    push <= 1'b0;
    while (curve_points.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_point_count(input logic [bcpe_pkg::CNT_W-1:0] cnt);
    logic [31:0] word;
    word = $urandom();
    word[bcpe_pkg::CNT_W-1:0] = cnt;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {bcpe_pkg::REG_POINT_COUNT, 2'b00};
    pwdata <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[bcpe_pkg::CNT_W-1:0] !== cnt)
      curve_points.report_error($sformatf("point_count read %0d exp %0d",
                                          prdata[bcpe_pkg::CNT_W-1:0], cnt));
    psel <= 1'b0;
    penable <= 1'b0;
    curve_points.set_point_count(cnt);
  endtask

  task automatic sample_edge();
    @(posedge clk_i);
    if (pop && !empty) curve_points.check_point(curve_x_o, curve_y_o);
  endtask

  task automatic take_results();
    int gap;
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) sample_edge();
      end
      pop <= 1'b1;
      repeat ($urandom_range(1, 12)) sample_edge();
    end
  endtask

  initial begin
    #(RUN_LIMIT_NS * 1ns);
    $display("FAIL bezier_curve_point_evaluator_core");
    $finish;
  end

  initial begin
    int eval_params [7];
    int phase_counts [13];
    eval_params = '{0, 1, ONE_PARAM / 2, ONE_PARAM - 1, ONE_PARAM, ONE_PARAM + 1,
                    2 * ONE_PARAM - 1};
    phase_counts = '{16, 0, 1, 31, 3, 17, 2, 9, 5, 16, 4, 12, 7};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    fork
      take_results();
    join_none

    // fill every slot first so no evaluation reads an unwritten point
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (i < 4)
        send_item(bcpe_pkg::FUNC_LOAD, bcpe_pkg::IDX_W'(i), i[0] ? 16'sh7FFF : 16'sh8000,
                  i[0] ? 16'sh8000 : 16'sh7FFF, rand_param());
      else
        send_item(bcpe_pkg::FUNC_LOAD, bcpe_pkg::IDX_W'(i), rand_coord(), rand_coord(),
                  rand_param());
      idle_sender(pick_gap());
    end
    foreach (eval_params[i]) begin
      send_item(bcpe_pkg::FUNC_EVAL, bcpe_pkg::IDX_W'($urandom()), rand_coord(),
                rand_coord(), PW'(eval_params[i]));
      idle_sender(pick_gap());
    end

    foreach (phase_counts[p]) begin
      wait_results_done();
      repeat (EVAL_LATENCY) @(posedge clk_i);
      write_point_count(bcpe_pkg::CNT_W'(phase_counts[p]));
      no_stall = (p % 5 == 3);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p % 4 == 1 && k == ITEMS_PER_PHASE / 2) wait_results_done();
        send_random_item();
      end
    end

    wait_results_done();
    repeat (EVAL_LATENCY) @(posedge clk_i);
    if (curve_points.errors == 0) begin
      $display("PASS bezier_curve_point_evaluator_core");
    end else begin
      $display("FAIL bezier_curve_point_evaluator_core");
    end
    $finish;
  end

endmodule
